/* sv/c2p_pkg.sv */
// shared types, constants and angle table functions for the cartesian to polar block
package c2p_pkg;

	localparam int CORDIC_W = 64;
	localparam int FRAC     = 60;
	localparam int N_W      = 54;
	localparam int ROOT_W   = N_W / 2;
	localparam int REM_W    = ROOT_W + 2;
	localparam int MAG_W    = 23;
	localparam int ANG_W    = 15;
	localparam int MULT_W   = 32;
	localparam int F_SPLIT  = 17;

	localparam logic [63:0] SUM_LIMIT = 64'd1000000000000;
	localparam logic [MAG_W-1:0] MAG_MAX = 23'd8388607;
	localparam logic [ANG_W-1:0] ANGLE_LIMIT = 15'd9000;
	localparam logic [63:0] DEG_FACTOR =
		((64'd18000 * 64'd100000000) << 20) / 64'd314159265;
	localparam logic [F_SPLIT-1:0] F_LO = DEG_FACTOR[F_SPLIT-1:0];
	localparam logic [15:0] F_HI = DEG_FACTOR[F_SPLIT+15:F_SPLIT];

	typedef struct packed {
		logic signed [CORDIC_W-1:0] cx;
		logic signed [CORDIC_W-1:0] cy;
		logic signed [CORDIC_W-1:0] z;
		logic [REM_W-1:0]           rem;
		logic [ROOT_W-1:0]          root;
		logic [N_W-1:0]             n;
	} core_t;

	typedef struct packed {
		logic x_zero;
		logic y_zero;
		logic y_neg;
		logic sat;
	} flags_t;

	function automatic logic [63:0] atan_pow2(input int unsigned i);
		logic [63:0] sum;
		logic [63:0] term;
		int unsigned k;
		sum = '0;
		for (k = 0; k < 31; k++) begin
			if (i * (2 * k + 1) <= 60) begin
				term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
				if (k[0]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_third();
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] term;
		int unsigned k;
		p = (64'd1 << 60) / 64'd3;
		sum = '0;
		for (k = 0; k < 32; k++) begin
			if (p != 64'd0) begin
				term = p / 64'(2 * k + 1);
				if (k[0]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
				p = p / 64'd9;
			end
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_entry(input int unsigned i);
		logic [63:0] r;
		if (i == 0) begin
			r = atan_pow2(1) + atan_third();
		end else begin
			r = atan_pow2(i);
		end
		return r;
	endfunction

endpackage

/* sv/cartesian_to_polar.sv */
// top level: point to magnitude and angle in hundredths, fully pipelined
// Point channel: point_valid with x_coord and y_coord; a request is taken on a
// rising edge with point_valid high and point_stall low.
// Polar channel: polar_valid with magnitude_hundredths, angle_hundredths and
// angle_undefined; a request leaves when polar_valid is high and polar_stall low.
// Throughput: one request per cycle while the pipeline is not held by a stall;
// every stage is a register stage with its own valid bit.
// Stages: three input stages (scaling, squares, scaled sum), one core stage per
// cordic step or per bit of the 27-bit square root, whichever are more, each
// doing the step and the root bit that fall to it, three output stages (angle to
// degrees, split product, rounding and clamping into the output register).
// Stall: while a result waits and polar_stall is high the whole pipeline holds
// and point_stall is high; nothing is dropped or repeated.
// Reset: arst_n clears all valid bits at once; the block takes requests as soon
// as reset is released.
module cartesian_to_polar import c2p_pkg::*; #(
	parameter int COORD_BITS    = 16,
	parameter int CORDIC_STAGES = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         point_valid,
	output logic                         point_stall,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	output logic                         polar_valid,
	input  logic                         polar_stall,
	output logic [MAG_W-1:0]             magnitude_hundredths,
	output logic signed [ANG_W-1:0]      angle_hundredths,
	output logic                         angle_undefined
);

	localparam int CORE_DEPTH = (CORDIC_STAGES > ROOT_W) ? CORDIC_STAGES : ROOT_W;

	logic en;
	logic core_v [CORE_DEPTH+1];
	core_t core_d [CORE_DEPTH+1];
	flags_t flags_d [CORE_DEPTH+1];

	assign en = !(polar_valid && polar_stall);
	assign point_stall = !en;

	c2p_prep #(
		.COORD_BITS(COORD_BITS)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_in(point_valid),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.valid_out(core_v[0]),
		.core_out(core_d[0]),
		.flags_out(flags_d[0])
	);

	for (genvar k = 0; k < CORE_DEPTH; k++) begin : g_core
		c2p_core_stage #(
			.IDX(k),
			.ROT_ON(k < CORDIC_STAGES),
			.ROOT_ON(k < ROOT_W)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_in(core_v[k]),
			.core_in(core_d[k]),
			.flags_in(flags_d[k]),
			.valid_out(core_v[k+1]),
			.core_out(core_d[k+1]),
			.flags_out(flags_d[k+1])
		);
	end

	c2p_post u_post (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_in(core_v[CORE_DEPTH]),
		.core_in(core_d[CORE_DEPTH]),
		.flags_in(flags_d[CORE_DEPTH]),
		.valid_out(polar_valid),
		.magnitude_hundredths(magnitude_hundredths),
		.angle_hundredths(angle_hundredths),
		.angle_undefined(angle_undefined)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		polar_valid && angle_undefined |-> angle_hundredths == '0 && magnitude_hundredths == '0)
		else $error("origin result carries nonzero angle or magnitude");

	assert property (@(posedge clk) disable iff (!arst_n)
		polar_valid && !angle_undefined |-> magnitude_hundredths != '0)
		else $error("point off the origin gave zero magnitude");

	assert property (@(posedge clk) disable iff (!arst_n)
		polar_valid |-> angle_hundredths <= signed'(ANGLE_LIMIT)
			&& angle_hundredths >= -signed'(ANGLE_LIMIT))
		else $error("angle outside plus or minus ninety degrees");
`endif

endmodule

/* sv/c2p_prep.sv */
// input stages: mirroring, fixed point scaling, squares and scaled sum of squares
module c2p_prep import c2p_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_in,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	output logic                         valid_out,
	output core_t                        core_out,
	output flags_t                       flags_out
);

	localparam int SQ_W = 2 * COORD_BITS;

	logic signed [COORD_BITS:0] xe, ye, mx, my, ay_full;
	logic signed [CORDIC_W-1:0] cx_s1, cy_s1, cx_s2, cy_s2;
	logic [COORD_BITS-1:0] ax_s1, ay_s1;
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sum;
	logic [39:0] s40;
	logic [N_W-1:0] s54, n_scaled;
	flags_t flags_s1, flags_s2, flags_s3;
	core_t core_s3;
	logic v_s1, v_s2, v_s3;

	assign xe = {x_coord[COORD_BITS-1], x_coord};
	assign ye = {y_coord[COORD_BITS-1], y_coord};
	assign mx = x_coord[COORD_BITS-1] ? -xe : xe;
	assign my = x_coord[COORD_BITS-1] ? -ye : ye;
	assign ay_full = y_coord[COORD_BITS-1] ? -ye : ye;

	assign sum = sqx_s2 + sqy_s2;
	assign s40 = 40'(sum);
	assign s54 = {14'b0, s40};
	// times 10000 as 8192 + 1024 + 512 + 256 + 16
	assign n_scaled = (s54 << 13) + (s54 << 10) + (s54 << 9) + (s54 << 8) + (s54 << 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= {{3{mx[COORD_BITS]}}, mx, {(FRAC - COORD_BITS){1'b0}}};
			cy_s1 <= {{3{my[COORD_BITS]}}, my, {(FRAC - COORD_BITS){1'b0}}};
			ax_s1 <= mx[COORD_BITS-1:0];
			ay_s1 <= ay_full[COORD_BITS-1:0];
			flags_s1.x_zero <= (x_coord == '0);
			flags_s1.y_zero <= (y_coord == '0);
			flags_s1.y_neg <= y_coord[COORD_BITS-1];
			flags_s1.sat <= 1'b0;

			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			sqx_s2 <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			sqy_s2 <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			flags_s2 <= flags_s1;

			core_s3.cx <= cx_s2;
			core_s3.cy <= cy_s2;
			core_s3.z <= '0;
			core_s3.rem <= '0;
			core_s3.root <= '0;
			core_s3.n <= n_scaled;
			flags_s3.x_zero <= flags_s2.x_zero;
			flags_s3.y_zero <= flags_s2.y_zero;
			flags_s3.y_neg <= flags_s2.y_neg;
			flags_s3.sat <= (64'(sum) > SUM_LIMIT);
		end
	end

	assign valid_out = v_s3;
	assign core_out = core_s3;
	assign flags_out = flags_s3;

endmodule

/* sv/c2p_core_stage.sv */
// one pipeline stage: a cordic vectoring step and one digit of the square root, each switched by ROT_ON and ROOT_ON
module c2p_core_stage import c2p_pkg::*; #(
	parameter int IDX     = 0,
	parameter bit ROT_ON  = 1'b1,
	parameter bit ROOT_ON = 1'b1
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   valid_in,
	input  core_t  core_in,
	input  flags_t flags_in,
	output logic   valid_out,
	output core_t  core_out,
	output flags_t flags_out
);

	localparam logic signed [CORDIC_W-1:0] ATAN = atan_entry(IDX);
	localparam int BIT_POS = ROOT_ON ? (N_W - 1 - 2 * IDX) : 1;

	logic signed [CORDIC_W-1:0] dx, dy;
	logic [REM_W-1:0] rem_t, trial;
	core_t nxt, core_s1;
	flags_t flags_s1;
	logic v_s1;

	assign dx = core_in.cy >>> IDX;
	assign dy = core_in.cx >>> IDX;
	assign rem_t = {core_in.rem[REM_W-3:0], core_in.n[BIT_POS -: 2]};
	assign trial = {core_in.root, 2'b01};

	always_comb begin
		nxt = core_in;
		if (ROT_ON) begin
			if (core_in.cy[CORDIC_W-1]) begin
				nxt.cx = core_in.cx - dx;
				nxt.cy = core_in.cy + dy;
				nxt.z = core_in.z - ATAN;
			end else begin
				nxt.cx = core_in.cx + dx;
				nxt.cy = core_in.cy - dy;
				nxt.z = core_in.z + ATAN;
			end
		end
		if (ROOT_ON) begin
			if (rem_t >= trial) begin
				nxt.rem = rem_t - trial;
				nxt.root = {core_in.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem = rem_t;
				nxt.root = {core_in.root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			core_s1 <= nxt;
			flags_s1 <= flags_in;
		end
	end

	assign valid_out = v_s1;
	assign core_out = core_s1;
	assign flags_out = flags_s1;

endmodule

/* sv/c2p_post.sv */
// output stages: degree conversion, rounding, clamping and the special cases
module c2p_post import c2p_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    valid_in,
	input  core_t                   core_in,
	input  flags_t                  flags_in,
	output logic                    valid_out,
	output logic [MAG_W-1:0]        magnitude_hundredths,
	output logic signed [ANG_W-1:0] angle_hundredths,
	output logic                    angle_undefined
);

	logic neg;
	logic [63:0] abs_z, m_full;
	logic [ROOT_W:0] rnd;
	logic [65:0] p, pr;
	logic [15:0] h;
	logic [ANG_W-1:0] hc;
	logic signed [ANG_W-1:0] ang;

	logic v_s1, v_s2, v_s3;
	logic neg_s1, neg_s2;
	logic [MULT_W-1:0] m_s1;
	logic [MAG_W-1:0] mag_s1, mag_s2, mag_s3;
	flags_t flags_s1, flags_s2;
	logic [47:0] pp_hi_s2;
	logic [48:0] pp_lo_s2;
	logic signed [ANG_W-1:0] ang_s3;
	logic undef_s3;

	assign neg = core_in.z[CORDIC_W-1];
	assign abs_z = neg ? 64'(-core_in.z) : 64'(core_in.z);
	assign m_full = abs_z + (64'd1 << 29);
	assign rnd = {1'b0, core_in.root} + (ROOT_W + 1)'(core_in.rem > {2'b0, core_in.root});

	assign p = 66'({pp_hi_s2, {F_SPLIT{1'b0}}}) + 66'(pp_lo_s2);
	assign pr = p + (66'd1 << 49);
	assign h = pr[65:50];
	assign hc = (h > 16'(ANGLE_LIMIT)) ? ANGLE_LIMIT : h[ANG_W-1:0];

	always_comb begin
		if (flags_s2.x_zero && flags_s2.y_zero) begin
			ang = '0;
		end else if (flags_s2.x_zero) begin
			ang = flags_s2.y_neg ? -signed'(ANGLE_LIMIT) : signed'(ANGLE_LIMIT);
		end else begin
			ang = neg_s2 ? -signed'(hc) : signed'(hc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= neg;
			m_s1 <= m_full[61:30];
			if (flags_in.sat || (rnd > (ROOT_W + 1)'(MAG_MAX))) begin
				mag_s1 <= MAG_MAX;
			end else begin
				mag_s1 <= rnd[MAG_W-1:0];
			end
			flags_s1 <= flags_in;

			neg_s2 <= neg_s1;
			pp_hi_s2 <= 48'(m_s1) * 48'(F_HI);
			pp_lo_s2 <= 49'(m_s1) * 49'(F_LO);
			mag_s2 <= mag_s1;
			flags_s2 <= flags_s1;

			ang_s3 <= ang;
			mag_s3 <= mag_s2;
			undef_s3 <= flags_s2.x_zero && flags_s2.y_zero;
		end
	end

	assign valid_out = v_s3;
	assign magnitude_hundredths = mag_s3;
	assign angle_hundredths = ang_s3;
	assign angle_undefined = undef_s3;

endmodule
